// File: hw/rtl/dnc_pkg.sv
// Shared types, widths and coefficient ROM for the detector nonlinearity corrector.
`default_nettype none

package dnc_pkg;

    // Field widths
    localparam int PIXEL_BITS = 18;
    localparam int SCALE_BITS = 18;
    localparam int SET_BITS   = 2;
    localparam int CHIP_BITS  = 2;

    // Dated coefficient sets present and chips per set
    localparam int NUM_SETS  = 4;
    localparam int NUM_CHIPS = 4;
    localparam int ROM_SETS  = 4;
    localparam int ROM_CHIPS = 4;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = SCALE_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_SET  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REF_SCALE = 1'd1;

    // Coefficient widths: a0 at 2^-23, a1 at 2^-44, a2 at 2^-60
    localparam int A0_W = 25;
    localparam int A1_W = 27;
    localparam int A2_W = 27;

    // Levels at 2^-8, saturated to +-(2^29 - 1)
    localparam int LVL_W = 30;
    localparam int PRD_W = PIXEL_BITS + SCALE_BITS + 1;  // pixel * scale at 2^-16
    localparam int REF_W = PRD_W - 7;                    // after rounding to 2^-8
    localparam int RAW_W = REF_W + 1;
    localparam int CLW   = (RAW_W > LVL_W) ? RAW_W : LVL_W + 1;

    // Polynomial datapath
    localparam int M2_W = LVL_W + A2_W;   // v * a2
    localparam int S1_W = 33;             // a1 + rnd(v*a2, 24)
    localparam int M1_W = LVL_W + S1_W;   // v * s1
    localparam int S0_W = 34;             // a0 + rnd(v*s1, 29)
    localparam int M0_W = LVL_W + S0_W;   // v * s0
    localparam int Y_W  = 41;             // rnd(v*s0, 23), 2^-8
    localparam int D_W  = Y_W + 1;        // raw minus ref
    localparam int R_W  = D_W - 7;        // difference in counts

    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel_value;
        logic [CHIP_BITS-1:0]         chip;
    } t_in_item;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] corrected_value;
        logic                         clipped;
    } t_out_item;

    typedef struct packed {
        logic signed [A0_W-1:0] a0;
        logic signed [A1_W-1:0] a1;
        logic signed [A2_W-1:0] a2;
    } t_coef;

    localparam t_coef IDENT_COEF = '{a0: 25'sd8388608, a1: 27'sd0, a2: 27'sd0};

    localparam t_coef COEF_ROM [ROM_SETS][ROM_CHIPS] = '{
        '{IDENT_COEF, IDENT_COEF, IDENT_COEF, IDENT_COEF},
        '{'{a0: 25'sd8344014, a1: 27'sd5553396,  a2: 27'sd52598008},
          '{a0: 25'sd8330081, a1: 27'sd27622019, a2: 27'sd42533580},
          '{a0: 25'sd8321742, a1: 27'sd30361826, a2: 27'sd39659693},
          '{a0: 25'sd8350826, a1: 27'sd15168810, a2: 27'sd61132279}},
        '{'{a0: 25'sd8378626, a1: 27'sd13934049, a2: 27'sd62180977},
          '{a0: 25'sd8362788, a1: 27'sd22636569, a2: 27'sd48284353},
          '{a0: 25'sd8372150, a1: 27'sd20264263, a2: 27'sd53476650},
          '{a0: 25'sd8359558, a1: 27'sd16348964, a2: 27'sd60605164}},
        '{'{a0: 25'sd8315426, a1: 27'sd30283365, a2: 27'sd8730683},
          '{a0: 25'sd8336146, a1: 27'sd32143915, a2: 27'sd22360913},
          '{a0: 25'sd8340407, a1: 27'sd33913513, a2: 27'sd19534756},
          '{a0: 25'sd8344979, a1: 27'sd26218866, a2: 27'sd32927784}}
    };

    // Rows outside the populated sets or chips fall back to identity
    function automatic t_coef coef_lookup(input logic [SET_BITS-1:0] set_sel,
                                          input logic [CHIP_BITS-1:0] chip_sel);
        t_coef c;
        c = IDENT_COEF;
        if (int'(set_sel) < NUM_SETS && int'(set_sel) < ROM_SETS &&
            int'(chip_sel) < NUM_CHIPS && int'(chip_sel) < ROM_CHIPS) begin
            c = COEF_ROM[set_sel][chip_sel];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dnc_poly_lane.sv
// One lane of the pipelined polynomial v*(a0 + v*(a1 + v*a2)), five register stages.
`default_nettype none

module dnc_poly_lane
    import dnc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [4:0]              i_load,
    input  wire logic signed [LVL_W-1:0] i_level,
    input  wire t_coef                   i_coef,
    output logic signed [Y_W-1:0]        o_y
);

    // stage A: v*a2
    logic signed [M2_W-1:0] r_m2;
    logic signed [LVL_W-1:0] r_v_a;
    logic signed [A0_W-1:0] r_a0_a;
    logic signed [A1_W-1:0] r_a1_a;
    // stage B: s1
    logic signed [S1_W-1:0] r_s1;
    logic signed [LVL_W-1:0] r_v_b;
    logic signed [A0_W-1:0] r_a0_b;
    // stage C: v*s1
    logic signed [M1_W-1:0] r_m1;
    logic signed [LVL_W-1:0] r_v_c;
    logic signed [A0_W-1:0] r_a0_c;
    // stage D: s0
    logic signed [S0_W-1:0] r_s0;
    logic signed [LVL_W-1:0] r_v_d;
    // stage E: v*s0
    logic signed [M0_W-1:0] r_m0;

    logic [M2_W:0] t2;
    logic [M1_W:0] t1;
    logic [M0_W:0] t0;
    logic signed [S1_W-1:0] n_s1;
    logic signed [S0_W-1:0] n_s0;
    logic signed [A0_W-1:0] coef_a0;
    logic signed [A1_W-1:0] coef_a1;
    logic signed [A2_W-1:0] coef_a2;

    assign coef_a0 = i_coef.a0;
    assign coef_a1 = i_coef.a1;
    assign coef_a2 = i_coef.a2;

    // round half up: add half an LSB, keep the upper bits (floor)
    assign t2 = {r_m2[M2_W-1], r_m2} + {{(M2_W-23){1'b0}}, 1'b1, 23'd0};
    assign t1 = {r_m1[M1_W-1], r_m1} + {{(M1_W-28){1'b0}}, 1'b1, 28'd0};
    assign t0 = {r_m0[M0_W-1], r_m0} + {{(M0_W-22){1'b0}}, 1'b1, 22'd0};

    assign n_s1 = r_a1_a + $signed(t2[24+S1_W-1:24]);
    assign n_s0 = r_a0_c + $signed(t1[29+S0_W-1:29]);
    assign o_y  = $signed(t0[23+Y_W-1:23]);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_m2   <= i_level * coef_a2;
            r_v_a  <= i_level;
            r_a0_a <= coef_a0;
            r_a1_a <= coef_a1;
        end
        if (i_load[1]) begin
            r_s1   <= n_s1;
            r_v_b  <= r_v_a;
            r_a0_b <= r_a0_a;
        end
        if (i_load[2]) begin
            r_m1   <= r_v_b * r_s1;
            r_v_c  <= r_v_b;
            r_a0_c <= r_a0_b;
        end
        if (i_load[3]) begin
            r_s0   <= n_s0;
            r_v_d  <= r_v_c;
        end
        if (i_load[4]) begin
            r_m0   <= r_v_d * r_s0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/detector_nonlinearity_correct.sv
// Top level: pipelined polynomial nonlinearity correction of CDS pixels.
`default_nettype none

// Takes one pixel per clock while o_in_ready is high and returns one corrected pixel
// per pixel, in order. The result passes through nine register stages, the first of
// which loads at acceptance. Each stage carries its own valid bit and only holds when
// the stage after it is full and held, so bubbles close up under backpressure and
// o_in_ready stays high while the pipe has room. The depth is set by the multiplier
// chain of the polynomial: three multiplies and two rounding adds for both levels,
// side by side.
// Write coef_set and ref_scale only while no pixel is in flight.

module detector_nonlinearity_correct
    import dnc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_in_item                 i_in_data,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_out_item                     o_out_data
);

    localparam int STAGES = 9;

    logic [SET_BITS-1:0]   r_coef_set;
    logic [SCALE_BITS-1:0] r_ref_scale;

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] n_valid;
    logic [STAGES-1:0] load;

    // stage 0
    logic signed [PIXEL_BITS-1:0] r0_pix;
    logic signed [PRD_W-1:0]      r0_prod;
    t_coef                        r0_coef;
    // stage 1
    logic signed [LVL_W-1:0]      r1_raw;
    logic signed [LVL_W-1:0]      r1_ref;
    t_coef                        r1_coef;
    // stage 7
    logic signed [D_W-1:0]        r7_diff;
    // stage 8
    t_out_item                    r_out;

    logic [PRD_W:0]               tp;
    logic signed [REF_W-1:0]      ref_q;
    logic signed [RAW_W-1:0]      raw_q;
    logic signed [Y_W-1:0]        y_raw;
    logic signed [Y_W-1:0]        y_ref;
    logic [D_W:0]                 td;
    logic signed [R_W-1:0]        res;
    t_out_item                    n_out;

    function automatic logic signed [LVL_W-1:0] clamp_level(input logic signed [CLW-1:0] v);
        logic signed [CLW-1:0] lim;
        logic signed [LVL_W-1:0] r;
        lim = CLW'({1'b0, {(LVL_W-1){1'b1}}});
        if (v > lim) begin
            r = LVL_W'(lim);
        end else if (v < -lim) begin
            r = LVL_W'(-lim);
        end else begin
            r = LVL_W'(v);
        end
        return r;
    endfunction

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_set  <= '0;
            r_ref_scale <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_SET:  r_coef_set  <= i_cfg_data[SET_BITS-1:0];
                CFG_REF_SCALE: r_ref_scale <= i_cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb begin
        load[STAGES-1] = !r_valid[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !r_valid[k] || load[k+1];
        end
        n_valid[0] = load[0] ? (i_in_valid && i_rst_n) : r_valid[0];
        for (int k = 1; k < STAGES; k++) begin
            n_valid[k] = load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    assign o_in_ready = load[0] && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stage 0: reference product and coefficient row
    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r0_pix  <= i_in_data.pixel_value;
            r0_prod <= i_in_data.pixel_value * $signed({1'b0, r_ref_scale});
            r0_coef <= coef_lookup(r_coef_set, i_in_data.chip);
        end
    end

    // stage 1: levels at 2^-8
    assign tp    = {r0_prod[PRD_W-1], r0_prod} + {{(PRD_W-7){1'b0}}, 1'b1, 7'd0};
    assign ref_q = $signed(tp[PRD_W:8]);
    assign raw_q = $signed({r0_pix, 8'd0}) + ref_q;

    always_ff @(posedge i_clk) begin
        if (load[1]) begin
            r1_raw  <= clamp_level(CLW'(raw_q));
            r1_ref  <= clamp_level(CLW'(ref_q));
            r1_coef <= r0_coef;
        end
    end

    // stages 2 to 6: polynomial on both levels
    dnc_poly_lane u_poly_raw (
        .i_clk   (i_clk),
        .i_load  (load[6:2]),
        .i_level (r1_raw),
        .i_coef  (r1_coef),
        .o_y     (y_raw)
    );

    dnc_poly_lane u_poly_ref (
        .i_clk   (i_clk),
        .i_load  (load[6:2]),
        .i_level (r1_ref),
        .i_coef  (r1_coef),
        .o_y     (y_ref)
    );

    // stage 7: difference
    always_ff @(posedge i_clk) begin
        if (load[7]) begin
            r7_diff <= y_raw - y_ref;
        end
    end

    // stage 8: round to counts and saturate
    assign td  = {r7_diff[D_W-1], r7_diff} + {{(D_W-7){1'b0}}, 1'b1, 7'd0};
    assign res = $signed(td[D_W:8]);

    always_comb begin
        if (res > R_W'(PIX_MAX)) begin
            n_out.corrected_value = PIX_MAX;
            n_out.clipped         = 1'b1;
        end else if (res < R_W'(PIX_MIN)) begin
            n_out.corrected_value = PIX_MIN;
            n_out.clipped         = 1'b1;
        end else begin
            n_out.corrected_value = PIXEL_BITS'(res);
            n_out.clipped         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[8]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid[STAGES-1];
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/dnc_checker.sv
// Port-level checks for the nonlinearity corrector, bound to the top level.
`default_nettype none

module dnc_checker
    import dnc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // saturation flag only with a range limit value
    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clipped |->
            (o_out_data.corrected_value == PIX_MAX ||
             o_out_data.corrected_value == PIX_MIN))
        else $error("clipped set on an unsaturated value");

    // empty output stage means the pipe can take a pixel
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input held off with an empty output stage");

    // reset empties the pipe
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind detector_nonlinearity_correct dnc_checker u_dnc_checker (.*);

`default_nettype wire

// File: bench/dnc_pixel_checker.sv
// Checker: predicts each corrected pixel and compares it with the block output.
`timescale 1ns / 1ps

module dnc_pixel_checker
    import dnc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire t_in_item                 i_in_data,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire t_out_item                i_out_data,
    output int                            o_err_count,
    output int                            o_pending
);

    localparam longint LEVEL_LIMIT = (longint'(1) << 29) - 1;
    localparam int     MAX_REPORTS = 10;

    logic [SET_BITS-1:0]   set_sel;
    logic [SCALE_BITS-1:0] scale_q16;
    t_out_item             corrected_q[$];
    int                    err_total;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        err_total   = 0;
        set_sel     = '0;
        scale_q16   = '0;
    end

    // Round half up at bit n (arithmetic shift floors)
    function automatic longint round_shift(input longint x, input int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_level(input longint v);
        if (v > LEVEL_LIMIT)
            return LEVEL_LIMIT;
        if (v < -LEVEL_LIMIT)
            return -LEVEL_LIMIT;
        return v;
    endfunction

    // a0 at 2^-23, a1 at 2^-44, a2 at 2^-60; set 0 is the identity set
    function automatic void coef_row(input logic [SET_BITS-1:0] set_idx,
                                     input logic [CHIP_BITS-1:0] chip_idx,
                                     output longint a0, output longint a1,
                                     output longint a2);
        a0 = 8388608;
        a1 = 0;
        a2 = 0;
        case ({set_idx, chip_idx})
            4'h4: begin a0 = 8344014; a1 = 5553396;  a2 = 52598008; end
            4'h5: begin a0 = 8330081; a1 = 27622019; a2 = 42533580; end
            4'h6: begin a0 = 8321742; a1 = 30361826; a2 = 39659693; end
            4'h7: begin a0 = 8350826; a1 = 15168810; a2 = 61132279; end
            4'h8: begin a0 = 8378626; a1 = 13934049; a2 = 62180977; end
            4'h9: begin a0 = 8362788; a1 = 22636569; a2 = 48284353; end
            4'ha: begin a0 = 8372150; a1 = 20264263; a2 = 53476650; end
            4'hb: begin a0 = 8359558; a1 = 16348964; a2 = 60605164; end
            4'hc: begin a0 = 8315426; a1 = 30283365; a2 = 8730683;  end
            4'hd: begin a0 = 8336146; a1 = 32143915; a2 = 22360913; end
            4'he: begin a0 = 8340407; a1 = 33913513; a2 = 19534756; end
            4'hf: begin a0 = 8344979; a1 = 26218866; a2 = 32927784; end
            default: ;
        endcase
    endfunction

    // v*(a0 + v*(a1 + v*a2)), level in and out at 2^-8
    function automatic longint level_poly(input longint v, input longint a0,
                                          input longint a1, input longint a2);
        longint s1;
        longint s0;
        s1 = a1 + round_shift(v * a2, 24);
        s0 = a0 + round_shift(v * s1, 29);
        return round_shift(v * s0, 23);
    endfunction

    function automatic t_out_item correct_pixel(input t_in_item item,
                                                input logic [SET_BITS-1:0] set_idx,
                                                input logic [SCALE_BITS-1:0] scale);
        longint    pix;
        longint    ref_q8;
        longint    raw_q8;
        longint    diff;
        longint    a0;
        longint    a1;
        longint    a2;
        t_out_item res;
        pix = longint'(item.pixel_value);
        coef_row(set_idx, item.chip, a0, a1, a2);
        ref_q8 = round_shift(pix * longint'(scale), 8);
        raw_q8 = clamp_level(pix * 256 + ref_q8);
        ref_q8 = clamp_level(ref_q8);
        diff = round_shift(level_poly(raw_q8, a0, a1, a2) - level_poly(ref_q8, a0, a1, a2), 8);
        res.clipped = 1'b0;
        if (diff > longint'(PIX_MAX)) begin
            diff = longint'(PIX_MAX);
            res.clipped = 1'b1;
        end else if (diff < longint'(PIX_MIN)) begin
            diff = longint'(PIX_MIN);
            res.clipped = 1'b1;
        end
        res.corrected_value = diff[PIXEL_BITS-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            corrected_q.delete();
            set_sel   = '0;
            scale_q16 = '0;
        end else begin
            // a register write takes effect for transactions after this edge
            if (i_in_valid && i_in_ready)
                corrected_q.push_back(correct_pixel(i_in_data, set_sel, scale_q16));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COEF_SET)
                    set_sel = i_cfg_data[SET_BITS-1:0];
                else if (i_cfg_idx == CFG_REF_SCALE)
                    scale_q16 = i_cfg_data[SCALE_BITS-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (corrected_q.size() == 0) begin
                    err_total++;
                    if (err_total <= MAX_REPORTS)
                        $display("unexpected result: value %0d clipped %0b",
                                 i_out_data.corrected_value, i_out_data.clipped);
                end else begin
                    want = corrected_q.pop_front();
                    if (want.corrected_value !== i_out_data.corrected_value ||
                        want.clipped !== i_out_data.clipped) begin
                        err_total++;
                        if (err_total <= MAX_REPORTS)
                            $display("mismatch: expected value %0d clipped %0b, got value %0d clipped %0b",
                                     want.corrected_value, want.clipped,
                                     i_out_data.corrected_value, i_out_data.clipped);
                    end
                end
            end
        end
        o_err_count <= err_total;
        o_pending   <= corrected_q.size();
    end

endmodule

// File: bench/tb_detector_nonlinearity_correct.sv
// Testbench top: drives pixels and coefficient settings, gives the verdict.
`timescale 1ns / 1ps

module tb_detector_nonlinearity_correct;
    import dnc_pkg::*;

    localparam int LATENCY     = 9;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int IDLE_PCT    = 21;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = CFG_COEF_SET;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in_data  = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out_data;

    int   err_count;
    int   pending_results;
    int   quiet_cycles = 0;
    logic steady_flow  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    detector_nonlinearity_correct dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    dnc_pixel_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_err_count (err_count),
        .o_pending   (pending_results)
    );

    always @(posedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: ends the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_pixel(input logic signed [PIXEL_BITS-1:0] pixel,
                              input logic [CHIP_BITS-1:0] chip);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{pixel_value: pixel, chip: chip};
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // Hold off until every corrected pixel is back and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [SET_BITS-1:0] set_sel,
                                input logic [SCALE_BITS-1:0] scale);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COEF_SET;
        i_cfg_data <= CFG_DATA_BITS'(set_sel);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_REF_SCALE;
        i_cfg_data <= CFG_DATA_BITS'(scale);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [SCALE_BITS-1:0] pick_scale();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_BITS'(65536);
            default: return SCALE_BITS'($urandom_range(262143));
        endcase
    endfunction

    function automatic logic signed [PIXEL_BITS-1:0] pick_pixel();
        logic signed [PIXEL_BITS-1:0] p;
        case ($urandom_range(9))
            5, 6:    p = PIXEL_BITS'($signed($urandom_range(510)) - 255);
            7:       p = PIX_MAX - PIXEL_BITS'($urandom_range(300));
            8:       p = PIX_MIN + PIXEL_BITS'($urandom_range(300));
            9:       p = PIXEL_BITS'($signed($urandom_range(8190)) - 4095);
            default: p = PIXEL_BITS'($urandom());
        endcase
        return p;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: identity set, no reference level
        send_pixel(0, 0);
        send_pixel(PIX_MAX, 1);
        send_pixel(PIX_MIN, 2);
        send_pixel(-1, 3);
        send_pixel(1, 0);
        wait_idle();

        // Largest scale, strongest curvature: drives the output into saturation
        program_regs(3, '1);
        send_pixel(PIX_MAX, 0);
        send_pixel(PIX_MAX, 1);
        send_pixel(PIX_MAX, 2);
        send_pixel(PIX_MAX, 3);
        send_pixel(PIX_MIN, 0);
        send_pixel(PIX_MIN, 3);
        send_pixel(-1, 1);
        send_pixel(0, 2);
        wait_idle();

        program_regs(1, SCALE_BITS'(65536));
        send_pixel(PIX_MAX, 2);
        send_pixel(PIX_MIN, 1);
        send_pixel(1000, 0);
        send_pixel(-1000, 3);
        send_pixel(131070, 1);
        wait_idle();

        program_regs(2, '0);
        send_pixel(PIX_MAX, 3);
        send_pixel(PIX_MIN, 0);
        send_pixel(77777, 2);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            program_regs(SET_BITS'($urandom_range(3)), pick_scale());
            steady_flow <= (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(pick_pixel(), CHIP_BITS'($urandom_range(3)));
            wait_idle();
        end
        steady_flow <= 1'b0;

        repeat (LATENCY * 4) @(posedge i_clk);
        if (err_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
